// ----- rtl/zfd_pkg.sv -----
// Package for the zstd frame deframer: item types, result kinds, error codes
// and parse phases. No dependencies.
package zfd_pkg;

	typedef struct packed {
		logic        operation;
		logic [7:0]  in_byte;
		logic        end_of_stream;
		logic [17:0] decoded_count;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [7:0]  data_byte;
		logic [17:0] run_length;
		logic        payload_last;
		logic [63:0] header_value;
		logic [63:0] content_size;
		logic        content_size_known;
		logic [3:0]  error_code;
	} out_item_t;

	localparam logic [2:0] K_RAW = 3'd0;
	localparam logic [2:0] K_RUN = 3'd1;
	localparam logic [2:0] K_PAY = 3'd2;
	localparam logic [2:0] K_FHDR = 3'd3;
	localparam logic [2:0] K_BHDR = 3'd4;
	localparam logic [2:0] K_CHK = 3'd5;
	localparam logic [2:0] K_DONE = 3'd6;
	localparam logic [2:0] K_ERR = 3'd7;

	localparam logic [3:0] E_SKIP = 4'd1;
	localparam logic [3:0] E_MAGIC = 4'd2;
	localparam logic [3:0] E_RSV = 4'd3;
	localparam logic [3:0] E_DICT = 4'd4;
	localparam logic [3:0] E_WIN = 4'd5;
	localparam logic [3:0] E_CLIM = 4'd6;
	localparam logic [3:0] E_BIG = 4'd7;
	localparam logic [3:0] E_BWIN = 4'd8;
	localparam logic [3:0] E_OLIM = 4'd9;
	localparam logic [3:0] E_BTYPE = 4'd10;
	localparam logic [3:0] E_TRUNC = 4'd11;
	localparam logic [3:0] E_CMIS = 4'd12;
	localparam logic [3:0] E_EMIS = 4'd13;
	localparam logic [3:0] E_TRAIL = 4'd14;

	localparam logic [1:0] R_MAXOUT = 2'd0;
	localparam logic [1:0] R_MAXWS = 2'd1;
	localparam logic [1:0] R_EXPLEN = 2'd2;
	localparam logic [1:0] R_EXPEN = 2'd3;

	localparam logic [47:0] MASK48 = 48'hFFFF_FFFF_FFFF;
	localparam logic [63:0] WS_SLACK = 64'd2097152;
	localparam logic [31:0] FRAME_MAGIC = 32'hFD2F_B528;
	localparam logic [31:0] SKIP_MAGIC = 32'h184D_2A50;

	typedef enum logic [12:0] {
		P_MAGIC = 13'h0001,
		P_DESC  = 13'h0002,
		P_WIN   = 13'h0004,
		P_DICT  = 13'h0008,
		P_CONT  = 13'h0010,
		P_BHDR  = 13'h0020,
		P_RAW   = 13'h0040,
		P_RLE   = 13'h0080,
		P_COMP  = 13'h0100,
		P_AWAIT = 13'h0200,
		P_CHK   = 13'h0400,
		P_DONE  = 13'h0800,
		P_ERR   = 13'h1000
	} phase_t;

endpackage

// ----- rtl/zfd_fifo.sv -----
// Two-entry item queue between the parser and the output port.
// Depends on zfd_pkg.
module zfd_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  zfd_pkg::out_item_t push_item,
	output logic              full,
	output logic              pop_valid,
	input  logic              pop_ready,
	output zfd_pkg::out_item_t pop_item
);
	zfd_pkg::out_item_t mem_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	logic pop;

	assign full = cnt_q == 2'd2;
	assign pop_valid = cnt_q != 2'd0;
	assign pop_item = mem_q[rp_q];
	assign pop = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= push_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule

// ----- rtl/zfd_parser.sv -----
// Front parser: accepts items, tracks the frame and block state and makes
// at most one result per item. Depends on zfd_pkg.
module zfd_parser #(
	parameter int MAX_BLOCK_BYTES = 131072
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              take,
	input  zfd_pkg::in_item_t item,
	input  logic [47:0]       max_out,
	input  logic [47:0]       max_ws,
	input  logic [47:0]       exp_len,
	input  logic              exp_en,
	output logic              res_valid,
	output zfd_pkg::out_item_t res
);
	localparam logic [17:0] MAXB = 18'(MAX_BLOCK_BYTES);

	zfd_pkg::phase_t phase_q, nphase;
	logic [3:0]  cnt_q, ncnt;
	logic [63:0] shf_q, nshf, acc;
	logic [7:0]  desc_q, ndesc;
	logic [63:0] win_q, nwin, dcont_q, ndcont, tot_q, ntot;
	logic        cdecl_q, ncdecl, last_q, nlast;
	logic [17:0] brem_q, nbrem;
	logic [17:0] brem_m1;
	logic        err_q, nerr;
	logic [3:0]  dlen, clen, fcnt;
	logic [63:0] wval, addn, room;
	logic [20:0] bsize;
	logic [17:0] blim;
	logic [1:0]  bkind;
	logic        olim;

	function automatic logic [3:0] dict_len(input logic [7:0] d);
		return (d[1:0] == 2'd3) ? 4'd4 : {2'b00, d[1:0]};
	endfunction
	function automatic logic [3:0] cont_len(input logic [7:0] d);
		case (d[7:6])
			2'd0: cont_len = d[5] ? 4'd1 : 4'd0;
			2'd1: cont_len = 4'd2;
			2'd2: cont_len = 4'd4;
			default: cont_len = 4'd8;
		endcase
	endfunction

	always_comb begin
		zfd_pkg::out_item_t r;
		logic hit;
		logic [3:0] e;
		logic fin;
		logic [63:0] wv;
		nphase = phase_q; ncnt = cnt_q; nshf = shf_q; ndesc = desc_q;
		nwin = win_q; ndcont = dcont_q; ncdecl = cdecl_q; nlast = last_q;
		nbrem = brem_q; ntot = tot_q; nerr = err_q;
		r = '0; hit = 1'b0; e = 4'd0; fin = 1'b0; wv = win_q;
		acc = shf_q | (64'(item.in_byte) << {cnt_q[2:0], 3'b000});
		fcnt = cnt_q + 4'd1;
		dlen = dict_len(desc_q);
		clen = cont_len(desc_q);
		// window = (8 + mantissa) << (exponent + 7)
		wval = 64'({1'b1, item.in_byte[2:0]}) << (6'(item.in_byte[7:3]) + 6'd7);
		bsize = acc[23:3];
		bkind = acc[2:1];
		blim = (win_q < 64'(MAXB)) ? win_q[17:0] : MAXB;
		brem_m1 = brem_q - 18'd1;
		addn = item.operation ? 64'(item.decoded_count) : 64'(bsize);
		room = 64'(max_out) - tot_q;
		olim = (tot_q > 64'(max_out)) || (addn > room);
		if (take && !err_q) begin
			if (item.operation) begin
				if (phase_q == zfd_pkg::P_AWAIT) begin
					if (olim) e = zfd_pkg::E_OLIM;
					else begin
						ntot = tot_q + addn;
						fin = 1'b1;
					end
				end
			end else if (phase_q == zfd_pkg::P_DONE) begin
				e = zfd_pkg::E_TRAIL;
			end else if (phase_q != zfd_pkg::P_AWAIT) begin
				unique case (phase_q)
					zfd_pkg::P_MAGIC: begin
						nshf = acc; ncnt = fcnt;
						if (fcnt == 4'd4) begin
							if ({acc[31:4], 4'h0} == zfd_pkg::SKIP_MAGIC) e = zfd_pkg::E_SKIP;
							else if (acc != 64'(zfd_pkg::FRAME_MAGIC)) e = zfd_pkg::E_MAGIC;
							else nphase = zfd_pkg::P_DESC;
						end
					end
					zfd_pkg::P_DESC: begin
						ndesc = item.in_byte; nwin = '0; ndcont = '0; ncdecl = 1'b0;
						ntot = '0;
						if (item.in_byte[3]) e = zfd_pkg::E_RSV;
						else if (!item.in_byte[5]) nphase = zfd_pkg::P_WIN;
						else begin
							// single segment: next is dict or content
							ncnt = '0; nshf = '0;
							if (dict_len(item.in_byte) != 0) nphase = zfd_pkg::P_DICT;
							else nphase = zfd_pkg::P_CONT;
						end
					end
					zfd_pkg::P_WIN: begin
						nwin = wval; wv = wval; ncnt = '0; nshf = '0;
						if (dlen != 0) nphase = zfd_pkg::P_DICT;
						else if (clen != 0) nphase = zfd_pkg::P_CONT;
						else hit = 1'b1;
					end
					zfd_pkg::P_DICT: begin
						nshf = acc; ncnt = fcnt;
						if (fcnt >= dlen) begin
							if (acc != 0) e = zfd_pkg::E_DICT;
							else begin
								ncnt = '0; nshf = '0;
								if (clen != 0) nphase = zfd_pkg::P_CONT;
								else hit = 1'b1;
							end
						end
					end
					zfd_pkg::P_CONT: begin
						nshf = acc; ncnt = fcnt;
						if (fcnt >= clen) begin
							ndcont = acc + ((clen == 4'd2) ? 64'd256 : 64'd0);
							ncdecl = 1'b1;
							if (desc_q[5]) begin nwin = ndcont; wv = ndcont; end
							hit = 1'b1;
						end
					end
					zfd_pkg::P_BHDR: begin
						nshf = acc; ncnt = fcnt;
						if (fcnt == 4'd3) begin
							nlast = acc[0];
							if (bsize > {3'd0, MAXB}) e = zfd_pkg::E_BIG;
							else if (bkind == 2'd3) e = zfd_pkg::E_BTYPE;
							else if (!bkind[1] && bsize > {3'd0, blim}) e = zfd_pkg::E_BWIN;
							else if (!bkind[1] && olim) e = zfd_pkg::E_OLIM;
							else begin
								nbrem = bsize[17:0];
								r.kind = zfd_pkg::K_BHDR; r.data_byte = {6'd0, bkind};
								r.run_length = bsize[17:0]; r.payload_last = acc[0];
								ncnt = '0; nshf = '0;
								case (bkind)
									2'd0: if (bsize == 0) fin = 1'b1;
										else nphase = zfd_pkg::P_RAW;
									2'd1: nphase = zfd_pkg::P_RLE;
									default: nphase = (bsize == 0) ? zfd_pkg::P_AWAIT
										: zfd_pkg::P_COMP;
								endcase
							end
						end
					end
					zfd_pkg::P_RAW: begin
						ntot = tot_q + 64'd1; nbrem = brem_m1;
						r.kind = zfd_pkg::K_RAW; r.data_byte = item.in_byte;
						r.payload_last = brem_m1 == 0;
						fin = brem_m1 == 0;
					end
					zfd_pkg::P_RLE: begin
						ntot = tot_q + 64'(brem_q);
						r.kind = zfd_pkg::K_RUN; r.data_byte = item.in_byte;
						r.run_length = brem_q;
						fin = 1'b1;
					end
					zfd_pkg::P_COMP: begin
						nbrem = brem_m1;
						r.kind = zfd_pkg::K_PAY; r.data_byte = item.in_byte;
						r.payload_last = brem_m1 == 0;
						if (brem_m1 == 0) nphase = zfd_pkg::P_AWAIT;
					end
					zfd_pkg::P_CHK: begin
						nshf = acc; ncnt = fcnt;
						if (fcnt == 4'd4) begin
							r.kind = zfd_pkg::K_CHK; r.header_value = acc;
							nphase = zfd_pkg::P_DONE;
						end
					end
					default: ;
				endcase
			end
			if (hit) begin
				if (wv > 64'(max_ws) || (64'(max_ws) - wv) < zfd_pkg::WS_SLACK)
					e = zfd_pkg::E_WIN;
				else if (ncdecl && ndcont > 64'(max_out)) e = zfd_pkg::E_CLIM;
				else begin
					nphase = zfd_pkg::P_BHDR; ncnt = '0; nshf = '0;
					r.kind = zfd_pkg::K_FHDR; r.header_value = wv;
					r.content_size = ndcont; r.content_size_known = ncdecl;
				end
			end
			if (fin && e == 4'd0) begin
				if (!nlast) begin
					nphase = zfd_pkg::P_BHDR; ncnt = '0; nshf = '0;
				end else if (cdecl_q && ntot != dcont_q) e = zfd_pkg::E_CMIS;
				else if (exp_en && ntot != 64'(exp_len)) e = zfd_pkg::E_EMIS;
				else if (desc_q[2]) begin
					nphase = zfd_pkg::P_CHK; ncnt = '0; nshf = '0;
				end else begin
					nphase = zfd_pkg::P_DONE;
					if (item.operation) r.kind = zfd_pkg::K_DONE;
				end
			end
			if (fin && item.operation && e == 4'd0 && nphase != zfd_pkg::P_DONE)
				r = '0;
			if (e == 4'd0 && !item.operation && item.end_of_stream &&
				phase_q != zfd_pkg::P_AWAIT && phase_q != zfd_pkg::P_DONE &&
				!(nphase == zfd_pkg::P_DONE ||
				(nphase == zfd_pkg::P_AWAIT && nlast && !desc_q[2])))
				e = zfd_pkg::E_TRUNC;
			if (e != 4'd0) begin
				r = '0; r.kind = zfd_pkg::K_ERR; r.error_code = e;
				nerr = 1'b1; nphase = zfd_pkg::P_ERR;
			end
		end
		res = r;
		res_valid = take && !err_q && (e != 4'd0 || r.kind != zfd_pkg::K_RAW ||
			(!item.operation && phase_q == zfd_pkg::P_RAW));
		if (take && !err_q && e == 4'd0 && r == '0 &&
			!(!item.operation && phase_q == zfd_pkg::P_RAW))
			res_valid = 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= zfd_pkg::P_MAGIC; cnt_q <= '0; shf_q <= '0; desc_q <= '0;
			win_q <= '0; dcont_q <= '0; cdecl_q <= 1'b0; brem_q <= '0;
			last_q <= 1'b0; tot_q <= '0; err_q <= 1'b0;
		end else begin
			phase_q <= nphase; cnt_q <= ncnt; shf_q <= nshf; desc_q <= ndesc;
			win_q <= nwin; dcont_q <= ndcont; cdecl_q <= ncdecl; brem_q <= nbrem;
			last_q <= nlast; tot_q <= ntot; err_q <= nerr;
		end
	end
endmodule

// ----- rtl/zstd_frame_deframer.sv -----
// Top level of the zstd frame deframer: config registers, parser, queue.
// Depends on zfd_pkg, zfd_parser, zfd_fifo.
// One item is taken per cycle; each item is parsed in the cycle it is accepted
// and its result, if any, enters a two-entry queue in front of the output, so
// input stalls only when that queue is full. A result is registered into the
// queue and reaches the output behind any results already waiting there.
module zstd_frame_deframer #(
	parameter int MAX_BLOCK_BYTES = 131072
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  zfd_pkg::in_item_t  in_item,
	output logic               out_valid,
	input  logic               out_ready,
	output zfd_pkg::out_item_t out_item,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [47:0]        cfg_data
);
	logic [47:0] max_out_q, max_ws_q, exp_len_q;
	logic exp_en_q, full, take, res_valid;
	zfd_pkg::out_item_t res;

	assign cfg_ready = 1'b1;
	assign in_ready = !full;
	assign take = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_out_q <= zfd_pkg::MASK48; max_ws_q <= zfd_pkg::MASK48;
			exp_len_q <= '0; exp_en_q <= 1'b0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				zfd_pkg::R_MAXOUT: max_out_q <= cfg_data;
				zfd_pkg::R_MAXWS:  max_ws_q <= cfg_data;
				zfd_pkg::R_EXPLEN: exp_len_q <= cfg_data;
				default:           exp_en_q <= cfg_data[0];
			endcase
		end
	end

	zfd_parser #(.MAX_BLOCK_BYTES(MAX_BLOCK_BYTES)) u_parser (
		.clk, .arst_n, .take, .item(in_item), .max_out(max_out_q), .max_ws(max_ws_q),
		.exp_len(exp_len_q), .exp_en(exp_en_q), .res_valid, .res
	);

	zfd_fifo u_fifo (
		.clk, .arst_n, .push(res_valid), .push_item(res), .full,
		.pop_valid(out_valid), .pop_ready(out_ready), .pop_item(out_item)
	);
endmodule

// ----- rtl/zfd_checker.sv -----
// Port-level checks for the zstd frame deframer, bound to the top level.
// Depends on zfd_pkg.
module zfd_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input zfd_pkg::out_item_t out_item
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_item)) else $error("out hold");
	a_err_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.kind == zfd_pkg::K_ERR |-> out_item.error_code != 4'd0)
		else $error("error code");
	a_no_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.kind != zfd_pkg::K_ERR |-> out_item.error_code == 4'd0)
		else $error("stray code");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready) else $error("stall while empty");
endmodule

bind zstd_frame_deframer zfd_checker u_chk (
	.clk, .arst_n, .in_valid, .in_ready, .out_valid, .out_ready, .out_item
);
